### src/ps2hbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2hbe_pkg
// Types and constants shared by the PS/2 host bit engine.
// ----------------------------------------------------------------------------
package ps2hbe_pkg;

  localparam int DataBits = 8;
  localparam int CountW   = 4;
  localparam logic [DataBits-1:0] ResendByte = 8'hFE;

  localparam logic OpEdge  = 1'b0;
  localparam logic OpWrite = 1'b1;

  typedef enum logic [3:0] {
    PH_RX_START  = 4'd0,
    PH_RX_DATA   = 4'd1,
    PH_RX_PARITY = 4'd2,
    PH_RX_STOP   = 4'd3,
    PH_TX_START  = 4'd4,
    PH_TX_DATA   = 4'd5,
    PH_TX_PARITY = 4'd6,
    PH_TX_STOP   = 4'd7,
    PH_TX_ACK    = 4'd8
  } phase_t;

  typedef struct packed {
    logic                opcode;
    logic                data_line;
    logic [DataBits-1:0] tx_byte;
  } item_t;

  typedef struct packed {
    logic                rx_valid;
    logic [DataBits-1:0] rx_byte;
    logic                drive_enable;
    logic                drive_level;
    logic                send_request;
    logic                frame_error;
  } result_t;

  typedef struct packed {
    phase_t              phase;
    logic [DataBits-1:0] shift_byte;
    logic [CountW-1:0]   bit_count;
    logic                running_parity;
    logic                received_parity;
  } link_state_t;

endpackage

### src/ps2hbe_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2hbe_step
// Next-state and result logic for one clock edge or write request.
// ----------------------------------------------------------------------------
module ps2hbe_step
  import ps2hbe_pkg::*;
(
  input  link_state_t st,
  input  item_t       item,
  output link_state_t st_next,
  output result_t     res
);

  logic [2:0] idx;
  logic       tx_bit;
  logic [CountW-1:0] cnt_inc;

  assign idx     = st.bit_count[2:0];
  assign tx_bit  = st.shift_byte[idx];
  assign cnt_inc = st.bit_count + CountW'(1);

  always_comb begin
    st_next = st;
    res     = '0;
    if (item.opcode == OpWrite) begin
      st_next.shift_byte = item.tx_byte;
      st_next.phase      = PH_TX_START;
      res.send_request   = 1'b1;
      res.drive_enable   = 1'b1;
    end else begin
      unique case (st.phase)
        PH_RX_DATA: begin
          st_next.shift_byte     = st.shift_byte | (DataBits'(item.data_line) << idx);
          st_next.bit_count      = cnt_inc;
          st_next.running_parity = st.running_parity ^ item.data_line;
          if (cnt_inc >= CountW'(DataBits)) st_next.phase = PH_RX_PARITY;
        end
        PH_RX_PARITY: begin
          st_next.received_parity = item.data_line;
          st_next.phase           = PH_RX_STOP;
        end
        PH_RX_STOP: begin
          if (item.data_line && (st.received_parity == st.running_parity)) begin
            res.rx_valid  = 1'b1;
            res.rx_byte   = st.shift_byte;
            st_next.phase = PH_RX_START;
          end else begin
            res.frame_error    = 1'b1;
            res.send_request   = 1'b1;
            res.drive_enable   = 1'b1;
            st_next.shift_byte = ResendByte;
            st_next.phase      = PH_TX_START;
          end
        end
        PH_TX_START: begin
          st_next.bit_count      = '0;
          st_next.running_parity = 1'b1;
          st_next.phase          = PH_TX_DATA;
          res.drive_enable       = 1'b1;
        end
        PH_TX_DATA: begin
          res.drive_enable       = 1'b1;
          res.drive_level        = tx_bit;
          st_next.running_parity = st.running_parity ^ tx_bit;
          st_next.bit_count      = cnt_inc;
          if (cnt_inc >= CountW'(DataBits)) st_next.phase = PH_TX_PARITY;
        end
        PH_TX_PARITY: begin
          res.drive_enable = 1'b1;
          res.drive_level  = st.running_parity;
          st_next.phase    = PH_TX_STOP;
        end
        PH_TX_STOP: begin
          st_next.phase = PH_TX_ACK;
        end
        PH_TX_ACK: begin
          st_next.phase = PH_RX_START;
        end
        default: begin
          if (!item.data_line) begin
            st_next.shift_byte     = '0;
            st_next.bit_count      = '0;
            st_next.running_parity = 1'b1;
            st_next.phase          = PH_RX_DATA;
          end else begin
            st_next.phase = PH_RX_START;
          end
        end
      endcase
    end
  end

endmodule

### src/ps2_host_bit_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_host_bit_engine_top
// Host side PS/2 bit engine: receive deframing, transmit framing, resend.
// ----------------------------------------------------------------------------
// One transaction per falling device clock edge or host write request. The
// engine accepts a transaction every cycle unless item_stall is high; each
// one yields exactly one result via the input register, then the result
// register. The link state register update sets the rate. A stalled result
// holds while the input register still takes one more transaction.
module ps2_host_bit_engine_top
  import ps2hbe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic        s_valid;
  item_t       s_item;
  link_state_t st;
  link_state_t st_next;
  result_t     res_next;
  logic        out_free;
  logic        advance;

  assign out_free   = !result_valid || !result_stall;
  assign advance    = s_valid && out_free;
  assign item_stall = s_valid && !out_free;

  ps2hbe_step u_step (
    .st      (st),
    .item    (s_item),
    .st_next (st_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid      <= 1'b0;
      result_valid <= 1'b0;
      st           <= '{phase: PH_RX_START, default: '0};
    end else begin
      if (!item_stall) begin
        s_valid <= item_valid;
      end
      if (out_free) begin
        result_valid <= advance;
      end
      if (advance) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s_item <= item;
    end
    if (advance) begin
      result <= res_next;
    end
  end

endmodule

### src/ps2hbe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2hbe_checker
// Port-level checks on the PS/2 host bit engine results.
// ----------------------------------------------------------------------------
module ps2hbe_checker
  import ps2hbe_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // stalled transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // a bad frame always starts the resend
  a_err_resend: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_error |->
      result.send_request && result.drive_enable && !result.drive_level)
    else $error("frame error without resend request");

  // a good byte never coincides with driving or errors
  a_rx_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.rx_valid |->
      !result.frame_error && !result.send_request && !result.drive_enable)
    else $error("received byte while driving");

  // released line reads low level, empty byte reads zero
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (result.drive_enable || !result.drive_level) &&
      (result.rx_valid || result.rx_byte == '0))
    else $error("stray level or byte");

  // input is never stalled while the output register is empty
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("input stalled with empty output");

endmodule

bind ps2_host_bit_engine_top ps2hbe_checker u_ps2hbe_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
